[sv/fgn_pkg.sv]
// ----------------------------------------------------------------------------
// fgn_pkg: shared types and constants for the fractal gradient noise block
// Field widths, register map, hash constants and sequencer states.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int COORD_W  = 32;
  localparam int NOISE_W  = 16;
  localparam int SEED_W   = 64;
  localparam int FREQ_W   = 32;
  localparam int AMP_W    = 17;
  localparam int NORM_W   = 32;
  localparam int CNT_W    = 4;
  localparam int PERS_W   = 16;
  localparam int LAC_W    = 16;
  localparam int LAC_SHIFT = 12;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  // Reciprocal numerator is 2^46 plus half the total: 47 bits, one quotient bit a step
  localparam int DIV_NUM_W = 47;
  localparam int DIV_CNT_W = 6;

  localparam int NOISE_MAX = 16384;

  localparam logic [SEED_W-1:0] SEED_RST = '0;
  localparam logic [CNT_W-1:0]  OCT_RST  = 4'd4;
  localparam logic [PERS_W-1:0] PERS_RST = 16'h8000;
  localparam logic [LAC_W-1:0]  LAC_RST  = 16'h2000;
  localparam logic [AMP_W-1:0]  AMP_ONE  = 17'h10000;

  localparam logic signed [31:0] HASH_MUL_X = 32'sd123456789;
  localparam logic signed [31:0] HASH_MUL_Y = 32'sd987654321;
  localparam logic [31:0]        HASH_MIX   = 32'h045d9f3b;
  localparam logic signed [31:0] DIAG_Q30   = 32'sd759250125;

  typedef enum logic [1:0] {
    REG_SEED     = 2'd0,
    REG_OCTAVES  = 2'd1,
    REG_PERSIST  = 2'd2,
    REG_LACUN    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_SCAN,
    CFG_DIV
  } cfg_state_t;

  typedef enum logic [2:0] {
    GRAD_PX,
    GRAD_NX,
    GRAD_PY,
    GRAD_NY,
    GRAD_PXPY,
    GRAD_NXPY,
    GRAD_PXNY,
    GRAD_NXNY
  } grad_t;

endpackage

[sv/fgn_in_if.sv]
// ----------------------------------------------------------------------------
// fgn_in_if: sample coordinate channel
// Valid/ready handshake carrying one point in signed Q16.16.
// ----------------------------------------------------------------------------
interface fgn_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fgn_pkg::COORD_W-1:0]  coord_x;
  logic signed [fgn_pkg::COORD_W-1:0]  coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

[sv/fgn_out_if.sv]
// ----------------------------------------------------------------------------
// fgn_out_if: noise result channel
// Valid/ready handshake carrying one Q1.14 noise value.
// ----------------------------------------------------------------------------
interface fgn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fgn_pkg::NOISE_W-1:0]  noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

[sv/fractal_gradient_noise_2d.sv]
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d: fractal gradient noise over up to MAX_OCTAVES
// Sums amplitude-weighted gradient noise octaves at a Q16.16 point and
// returns the normalised, clamped result in Q1.14.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------
//   sample   | in  | valid / ready        | coord_x, coord_y (s32 Q16.16)
//   result   | out | valid / ready        | noise_value (s16 Q1.14)
//   apb      | in  | psel/penable/pwrite  | paddr[4:0], pwdata/prdata 64b
//
// One transfer in per cycle while result is not stalled and no table build runs;
// each result passes 14 octave stages in parallel lanes, then sum, sum, scale, clamp.
// After reset, and after every register write, the sequencer builds the per-octave
// tables and the bit-serial reciprocal; sample.ready is low while it does so.
// A stall on result holds the whole pipe in place: nothing is dropped or
// repeated. Reset is synchronous, clears the valid bits and restarts the sequencer.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  fgn_in_if.sink                          sample,
  fgn_out_if.source                       result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fgn_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fgn_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fgn_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import fgn_pkg::*;

  localparam int F        = FRAC_BITS;
  localparam int VW       = F + 8;
  localparam int WW       = VW + AMP_W + 1;
  localparam int AW       = WW + 4;
  localparam int QW       = F + 10;
  localparam int PRW      = QW + NORM_W + 1;
  localparam int NG       = (MAX_OCTAVES + 3) / 4;
  localparam int LANE_LAT = 14;
  localparam int LAT      = LANE_LAT + 4;
  localparam logic signed [PRW-1:0] RND   = PRW'(1) <<< (F + 15);
  localparam logic signed [PRW-1:0] R_MAX = PRW'(NOISE_MAX);
  localparam logic signed [PRW-1:0] R_MIN = -R_MAX;

  logic [FREQ_W-1:0] freq_tab [MAX_OCTAVES];
  logic [SEED_W-1:0] seed_tab [MAX_OCTAVES];
  logic [AMP_W-1:0]  amp_tab  [MAX_OCTAVES];
  logic [NORM_W-1:0] norm;
  logic              cfg_busy;

  logic              adv;
  logic [LAT-1:0]    vld;

  logic signed [WW-1:0] weighted [MAX_OCTAVES];
  logic signed [WW-1:0] wpad [NG*4];
  logic signed [AW-1:0] grp_next [NG];
  logic signed [AW-1:0] grp [NG];
  logic signed [AW-1:0] acc_next;
  logic signed [AW-1:0] acc;
  logic signed [QW-1:0] acc_q;
  logic signed [PRW-1:0] scaled;
  logic signed [PRW-1:0] rounded;
  logic signed [NOISE_W-1:0] noise_next;
  logic signed [NOISE_W-1:0] noise_out;

  fgn_cfg #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .busy     (cfg_busy),
    .freq_tab (freq_tab),
    .seed_tab (seed_tab),
    .amp_tab  (amp_tab),
    .norm     (norm)
  );

  // Advance the whole pipe unless a finished result waits at the output
  assign adv          = !vld[LAT-1] || result.ready;
  assign sample.ready = adv && !cfg_busy;
  assign result.valid = vld[LAT-1];
  assign result.noise_value = noise_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], sample.valid && sample.ready};
    end
  end

  // One lane per octave; inactive octaves carry zero amplitude
  for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_lane
    fgn_octave #(
      .FRAC_BITS (FRAC_BITS)
    ) u_oct (
      .clk      (clk),
      .en       (adv),
      .coord_x  (sample.coord_x),
      .coord_y  (sample.coord_y),
      .freq     (freq_tab[gi]),
      .seed     (seed_tab[gi]),
      .amp      (amp_tab[gi]),
      .weighted (weighted[gi])
    );
  end

  for (genvar gj = 0; gj < NG * 4; gj++) begin : g_pad
    if (gj < MAX_OCTAVES) begin : g_used
      assign wpad[gj] = weighted[gj];
    end else begin : g_zero
      assign wpad[gj] = '0;
    end
  end

  // Two-level adder tree: groups of four, then the group sums
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < 4; k++) begin
        grp_next[g] = grp_next[g] + AW'(wpad[4*g + k]);
      end
    end
    acc_next = '0;
    for (int g = 0; g < NG; g++) begin
      acc_next = acc_next + grp[g];
    end
  end

  assign acc_q   = QW'(acc >>> 16);
  assign rounded = (scaled + RND) >>> (F + 16);

  // Clamp to plus or minus one in Q1.14
  always_comb begin
    if (rounded > R_MAX) begin
      noise_next = NOISE_W'(R_MAX);
    end else if (rounded < R_MIN) begin
      noise_next = NOISE_W'(R_MIN);
    end else begin
      noise_next = NOISE_W'(rounded);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp       <= grp_next;
      acc       <= acc_next;
      scaled    <= acc_q * $signed({1'b0, norm});
      noise_out <= noise_next;
    end
  end

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (noise_out <= 16'sd16384 && noise_out >= -16'sd16384))
    else $error("noise value outside plus or minus one");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.noise_value)))
    else $error("waiting result changed before its transfer");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_busy |-> !sample.ready)
    else $error("sample accepted while the tables are being built");

endmodule

[sv/fgn_cfg.sv]
// ----------------------------------------------------------------------------
// fgn_cfg: register file and per-octave table sequencer
// Holds the APB registers, builds frequency, seed and amplitude tables and
// the reciprocal of the amplitude total after reset and every write.
// ----------------------------------------------------------------------------
module fgn_cfg #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fgn_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fgn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fgn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic                              busy,
  output logic [fgn_pkg::FREQ_W-1:0]        freq_tab [MAX_OCTAVES],
  output logic [fgn_pkg::SEED_W-1:0]        seed_tab [MAX_OCTAVES],
  output logic [fgn_pkg::AMP_W-1:0]         amp_tab  [MAX_OCTAVES],
  output logic [fgn_pkg::NORM_W-1:0]        norm
);
  import fgn_pkg::*;

  localparam int CW = $clog2(MAX_OCTAVES + 1);
  localparam int IW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int TW = AMP_W + $clog2(MAX_OCTAVES);
  localparam logic [4:0] MAX5 = 5'(MAX_OCTAVES);
  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1) << FRAC_BITS;

  logic [SEED_W-1:0] seed_reg;
  logic [CNT_W-1:0]  oct_reg;
  logic [PERS_W-1:0] pers_reg;
  logic [LAC_W-1:0]  lac_reg;

  cfg_state_t           state, state_next;
  logic [CW-1:0]        scan_idx, scan_idx_next;
  logic [FREQ_W-1:0]    freq, freq_next;
  logic [AMP_W-1:0]     amp, amp_next;
  logic [TW-1:0]        total, total_next;
  logic [TW-1:0]        rem, rem_next;
  logic [DIV_NUM_W-1:0] quo, quo_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic [NORM_W-1:0]    norm_next;

  logic        wr;
  cfg_reg_t    reg_sel;
  logic [4:0]  n_eff;
  logic        active;
  logic        tab_we;
  logic [47:0] freq_prod;
  logic [35:0] freq_sh;
  logic [32:0] amp_prod;
  logic [TW:0] rem_sh;
  logic        qbit;

  assign wr      = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[4:3]);
  assign pready  = 1'b1;
  assign busy    = (state != CFG_IDLE);

  always_comb begin
    case (reg_sel)
      REG_SEED:    prdata = seed_reg;
      REG_OCTAVES: prdata = APB_DATA_W'(oct_reg);
      REG_PERSIST: prdata = APB_DATA_W'(pers_reg);
      REG_LACUN:   prdata = APB_DATA_W'(lac_reg);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= SEED_RST;
      oct_reg  <= OCT_RST;
      pers_reg <= PERS_RST;
      lac_reg  <= LAC_RST;
    end else if (wr) begin
      case (reg_sel)
        REG_SEED:    seed_reg <= pwdata;
        REG_OCTAVES: oct_reg  <= pwdata[CNT_W-1:0];
        REG_PERSIST: pers_reg <= pwdata[PERS_W-1:0];
        REG_LACUN:   lac_reg  <= pwdata[LAC_W-1:0];
        default:     ;
      endcase
    end
  end

  // Count of zero acts as one; clamp above the lane count
  always_comb begin
    if (oct_reg == '0) begin
      n_eff = 5'd1;
    end else if (5'(oct_reg) > MAX5) begin
      n_eff = MAX5;
    end else begin
      n_eff = 5'(oct_reg);
    end
  end

  assign active    = 5'(scan_idx) < n_eff;
  assign freq_prod = freq * lac_reg;
  assign freq_sh   = freq_prod[47:LAC_SHIFT];
  assign amp_prod  = amp * pers_reg;
  assign rem_sh    = {rem, quo[DIV_NUM_W-1]};
  assign qbit      = rem_sh >= {1'b0, total};

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    freq_next     = freq;
    amp_next      = amp;
    total_next    = total;
    rem_next      = rem;
    quo_next      = quo;
    div_cnt_next  = div_cnt;
    norm_next     = norm;
    tab_we        = 1'b0;
    case (state)
      CFG_IDLE: ;
      CFG_SCAN: begin
        tab_we        = 1'b1;
        total_next    = total + (active ? TW'(amp) : '0);
        freq_next     = (|freq_sh[35:32]) ? '1 : freq_sh[31:0];
        amp_next      = amp_prod[32:16];
        scan_idx_next = scan_idx + 1'b1;
        if (scan_idx == CW'(MAX_OCTAVES - 1)) begin
          state_next   = CFG_DIV;
          rem_next     = '0;
          quo_next     = (DIV_NUM_W'(1) << (DIV_NUM_W - 1)) + DIV_NUM_W'(total_next >> 1);
          div_cnt_next = '0;
        end
      end
      CFG_DIV: begin
        rem_next     = qbit ? TW'(rem_sh - {1'b0, total}) : rem_sh[TW-1:0];
        quo_next     = {quo[DIV_NUM_W-2:0], qbit};
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          state_next = CFG_IDLE;
          norm_next  = quo_next[NORM_W-1:0];
        end
      end
      default: state_next = CFG_IDLE;
    endcase
    // A write restarts the table build with the new values
    if (wr) begin
      state_next    = CFG_SCAN;
      scan_idx_next = '0;
      freq_next     = FREQ_ONE;
      amp_next      = AMP_ONE;
      total_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CFG_SCAN;
      scan_idx <= '0;
      freq     <= FREQ_ONE;
      amp      <= AMP_ONE;
      total    <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      freq     <= freq_next;
      amp      <= amp_next;
      total    <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    quo     <= quo_next;
    div_cnt <= div_cnt_next;
    norm    <= norm_next;
    if (tab_we) begin
      freq_tab[scan_idx[IW-1:0]] <= freq;
      seed_tab[scan_idx[IW-1:0]] <= seed_reg + SEED_W'(scan_idx);
      amp_tab[scan_idx[IW-1:0]]  <= active ? amp : '0;
    end
  end

  a_write_starts_build: assert property (@(posedge clk) disable iff (rst)
    wr |=> busy)
    else $error("register write did not start a table build");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (norm <= 32'h4000_0000 && norm >= 32'h0400_0000))
    else $error("amplitude reciprocal out of range");

  a_scan_before_div: assert property (@(posedge clk) disable iff (rst)
    (state == CFG_DIV && !$past(wr)) |-> ($past(state) == CFG_SCAN || $past(state) == CFG_DIV))
    else $error("reciprocal started without a table scan");

endmodule

[sv/fgn_octave.sv]
// ----------------------------------------------------------------------------
// fgn_octave: one octave of gradient noise, 14 register stages
// Scales the point, hashes the four corners, fades, blends, shapes and
// weights the octave value by its amplitude.
// ----------------------------------------------------------------------------
module fgn_octave #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fgn_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [fgn_pkg::COORD_W-1:0]  coord_y,
  input  logic [fgn_pkg::FREQ_W-1:0]          freq,
  input  logic [fgn_pkg::SEED_W-1:0]          seed,
  input  logic [fgn_pkg::AMP_W-1:0]           amp,
  output logic signed [FRAC_BITS+8+fgn_pkg::AMP_W:0] weighted
);
  import fgn_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = F + 8;
  localparam int PW  = 2 * VW;
  localparam int DPW = VW + 31;
  localparam logic signed [VW-1:0]  ONE      = VW'(1) <<< F;
  localparam logic signed [VW-1:0]  TEN      = VW'(10) <<< F;
  localparam logic signed [VW-1:0]  ONE_HALF3 = VW'(3) <<< (F - 1);
  localparam logic signed [DPW-1:0] DIAG_RND = DPW'(1) <<< 29;

  // Stage 1: scale by frequency
  logic signed [63:0] s1_prod [2];
  // Stage 2: lattice products and fraction squares
  logic signed [63:0] s2_k [2][2];
  logic [F-1:0]       s2_f [2];
  logic [2*F-1:0]     s2_ff [2];
  // Stage 3: first mix partial products
  logic [63:0]        s3_pl [4];
  logic [31:0]        s3_ph [4];
  logic [F-1:0]       s3_t2 [2];
  logic [2*F-1:0]     s3_t3p [2];
  logic [F-1:0]       s3_f [2];
  // Stage 4
  logic [18:0]        s4_t1 [4];
  logic signed [PW-1:0] s4_fp [2];
  logic [F-1:0]       s4_f [2];
  // Stage 5
  logic [18:0]        s5_h2 [4];
  logic signed [VW-1:0] s5_fd [2];
  logic [F-1:0]       s5_f [2];
  // Stages 6 to 14
  logic signed [VW-1:0]  s6_s [4];
  logic signed [DPW-1:0] s6_dp [4];
  logic                  s6_diag [4];
  logic signed [VW-1:0]  s6_u, s6_v, s7_u, s7_v, s8_v, s9_v;
  logic signed [VW-1:0]  s7_g [4];
  logic signed [PW-1:0]  s8_plo, s8_phi;
  logic signed [VW-1:0]  s8_a, s8_b;
  logic signed [VW-1:0]  s9_lo, s9_hi;
  logic signed [PW-1:0]  s10_pv;
  logic signed [VW-1:0]  s10_lo;
  logic signed [VW-1:0]  s11_m;
  logic signed [PW-1:0]  s12_sq;
  logic signed [VW-1:0]  s12_m;
  logic signed [PW-1:0]  s13_mc;

  logic signed [63:0]    px [2];
  logic [31:0]           lat_idx [2];
  logic [31:0]           lat_idx1 [2];
  logic [63:0]           t0 [4];
  logic [63:0]           h1 [4];
  logic [63:0]           t1 [4];
  logic signed [VW-1:0]  p_poly [2];
  logic signed [VW-1:0]  s_sel [4];
  logic                  d_sel [4];
  logic signed [VW-1:0]  dxy [2][2];
  logic [2:0]            hash3 [4];
  logic signed [VW-1:0]  gval [4];
  logic signed [VW-1:0]  curve_c;
  logic signed [VW-1:0]  oct_n;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      px[a]       = s1_prod[a] >>> 16;
      lat_idx[a]  = px[a][F +: 32];
      lat_idx1[a] = lat_idx[a] + 32'd1;
      p_poly[a] = $signed(VW'(s3_t2[a]) * VW'(6) + TEN - VW'(s3_f[a]) * VW'(15));
      dxy[a][0] = $signed(VW'(s5_f[a]));
      dxy[a][1] = $signed(VW'(s5_f[a])) - ONE;
    end
    for (int c = 0; c < 4; c++) begin
      t0[c] = seed ^ s2_k[0][c[1]] ^ s2_k[1][c[0]];
      t0[c] = t0[c] ^ (t0[c] >> 16);
      h1[c] = s3_pl[c] + {s3_ph[c], 32'd0};
      t1[c] = h1[c] ^ (h1[c] >> 16);
      hash3[c] = s5_h2[c][2:0] ^ s5_h2[c][18:16];
      d_sel[c] = 1'b0;
      case (grad_t'(hash3[c]))
        GRAD_PX:   s_sel[c] = dxy[0][c[1]];
        GRAD_NX:   s_sel[c] = -dxy[0][c[1]];
        GRAD_PY:   s_sel[c] = dxy[1][c[0]];
        GRAD_NY:   s_sel[c] = -dxy[1][c[0]];
        GRAD_PXPY: begin
          s_sel[c] = dxy[0][c[1]] + dxy[1][c[0]];
          d_sel[c] = 1'b1;
        end
        GRAD_NXPY: begin
          s_sel[c] = dxy[1][c[0]] - dxy[0][c[1]];
          d_sel[c] = 1'b1;
        end
        GRAD_PXNY: begin
          s_sel[c] = dxy[0][c[1]] - dxy[1][c[0]];
          d_sel[c] = 1'b1;
        end
        default: begin
          s_sel[c] = -dxy[0][c[1]] - dxy[1][c[0]];
          d_sel[c] = 1'b1;
        end
      endcase
      // Diagonal gradients scale by 1/sqrt(2), rounded half up
      gval[c] = s6_diag[c] ? VW'((s6_dp[c] + DIAG_RND) >>> 30) : s6_s[c];
    end
    curve_c = ONE_HALF3 - (VW'(s12_sq >>> F) >>> 1);
    oct_n   = VW'(s13_mc >>> F);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod[0] <= coord_x * $signed({1'b0, freq});
      s1_prod[1] <= coord_y * $signed({1'b0, freq});
      for (int a = 0; a < 2; a++) begin
        s2_f[a]  <= px[a][F-1:0];
        s2_ff[a] <= (2*F)'(px[a][F-1:0]) * (2*F)'(px[a][F-1:0]);
        s3_t2[a] <= s2_ff[a][2*F-1:F];
        s3_t3p[a] <= (2*F)'(s2_ff[a][2*F-1:F]) * (2*F)'(s2_f[a]);
        s3_f[a]  <= s2_f[a];
        s4_fp[a] <= $signed(VW'(s3_t3p[a][2*F-1:F])) * p_poly[a];
        s4_f[a]  <= s3_f[a];
        s5_fd[a] <= VW'(s4_fp[a] >>> F);
        s5_f[a]  <= s4_f[a];
      end
      s2_k[0][0] <= $signed(lat_idx[0]) * HASH_MUL_X;
      s2_k[0][1] <= $signed(lat_idx1[0]) * HASH_MUL_X;
      s2_k[1][0] <= $signed(lat_idx[1]) * HASH_MUL_Y;
      s2_k[1][1] <= $signed(lat_idx1[1]) * HASH_MUL_Y;
      for (int c = 0; c < 4; c++) begin
        s3_pl[c]   <= 64'(t0[c][31:0]) * 64'(HASH_MIX);
        s3_ph[c]   <= t0[c][63:32] * HASH_MIX;
        s4_t1[c]   <= t1[c][18:0];
        s5_h2[c]   <= s4_t1[c] * HASH_MIX[18:0];
        s6_s[c]    <= s_sel[c];
        s6_dp[c]   <= s_sel[c] * DIAG_Q30;
        s6_diag[c] <= d_sel[c];
        s7_g[c]    <= gval[c];
      end
      s6_u <= s5_fd[0];
      s6_v <= s5_fd[1];
      s7_u <= s6_u;
      s7_v <= s6_v;
      s8_v <= s7_v;
      s9_v <= s8_v;
      s8_plo <= s7_u * (s7_g[2] - s7_g[0]);
      s8_phi <= s7_u * (s7_g[3] - s7_g[1]);
      s8_a   <= s7_g[0];
      s8_b   <= s7_g[1];
      s9_lo  <= s8_a + VW'(s8_plo >>> F);
      s9_hi  <= s8_b + VW'(s8_phi >>> F);
      s10_pv <= s9_v * (s9_hi - s9_lo);
      s10_lo <= s9_lo;
      s11_m  <= (s10_lo + VW'(s10_pv >>> F)) <<< 1;
      s12_sq <= s11_m * s11_m;
      s12_m  <= s11_m;
      s13_mc <= s12_m * curve_c;
      weighted <= oct_n * $signed({1'b0, amp});
    end
  end

endmodule
